[design/lmt_pkg.sv]
package lmt_pkg;

  // Default sizes handed to the top level
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned DEF_PIXEL_BITS = 16;

  // Neighborhood radius and window span
  localparam int unsigned RADIUS = 1;
  localparam int unsigned WIN    = 2 * RADIUS + 1;

  // Fixed field widths
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned PIX_IN_W = 16;
  localparam int unsigned POS_W    = 12;

  // Register port
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned REG_SEL_LSB = 2;
  localparam int unsigned RST_WIDTH   = 640;
  localparam int unsigned RST_HEIGHT  = 480;

  // Result queue depth, a power of two
  localparam int unsigned RES_DEPTH = 8;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_e;

  typedef struct packed {
    logic             above_mean;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_in_run;
    logic             end_of_frame;
  } res_t;

endpackage

[design/lmt_in_if.sv]
interface lmt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [lmt_pkg::PIX_IN_W-1:0] pixel;

  modport source (output valid, mode, pixel, input ready);
  modport sink (input valid, mode, pixel, output ready);
endinterface

[design/lmt_out_if.sv]
interface lmt_out_if;
  logic                      valid;
  logic                      ready;
  logic                      above_mean;
  logic [lmt_pkg::POS_W-1:0] out_row;
  logic [lmt_pkg::POS_W-1:0] out_col;
  logic                      last_in_run;
  logic                      end_of_frame;

  modport source (output valid, above_mean, out_row, out_col, last_in_run, end_of_frame,
                  input ready);
  modport sink (input valid, above_mean, out_row, out_col, last_in_run, end_of_frame,
                output ready);
endinterface

[design/local_mean_threshold_3x3.sv]
// Local-mean threshold over a 3x3 neighborhood, one pixel word per cycle unless stalled.
// pix_i takes words in raster order: mode 0 carries a pixel, mode 1 is a drain
// word. A pixel of row r releases the results of row r-1 (one per word but for
// column 0, two on the last); after the frame's last pixel, one drain word per column
// releases the last row. A pixel word while draining, or a drain word outside
// draining, is taken and dropped. Results leave on res_o in raster order with
// their row and column, last_in_run on the final result of each word and
// end_of_frame on the frame's last pixel.
// Throughput is one word per cycle while pix_i.ready is high, set by the one
// read-modify-write that each word makes on the two line memories (read at
// accept, write in the next cycle, with forwarding into the next read). A result
// passes the s1 and s2 stages and the result queue before it shows on res_o. An
// 8-entry result queue parts the two sides: when the receiver stalls, the queue
// fills and pix_i.ready drops while the words still in flight could overflow it.
// Register writes on the APB port (frame_width at 0x0, frame_height at 0x4)
// restart the stream at row 0, column 0; write them only while idle.
// Reset restores the default 640x480 frame and an empty pipeline; the line
// memories need no clearing pass.
module local_mean_threshold_3x3 #(
  parameter int unsigned MAX_WIDTH  = lmt_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lmt_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = lmt_pkg::DEF_PIXEL_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lmt_in_if.sink                      pix_i,
  lmt_out_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lmt_pkg::APB_AW-1:0]  paddr,
  input  logic [lmt_pkg::APB_DW-1:0]  pwdata,
  output logic [lmt_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import lmt_pkg::*;

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned PW    = PIXEL_BITS;
  localparam int unsigned CS_W  = PW + 2;
  localparam int unsigned SUM_W = PW + 4;
  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
  localparam int unsigned OCC_W = CNT_W + 1;

  typedef logic [PW-1:0] pix_t;
  typedef logic [CS_W-1:0] csum_t;

  // Word as it travels through the pipeline
  typedef struct packed {
    logic          drain;   // drain word
    logic          first;   // drain word for column 0
    logic [AW-1:0] col;     // store column of the word
    logic [AW-1:0] ocol;    // column of the first result
    logic [RW-1:0] orow;    // row of the results
    pix_t          pixel;
    logic          top_ok;  // row above the center lies in frame
    logic          bot_ok;  // row below the center lies in frame
    logic          lft_a;   // left neighbor of first result in frame
    logic          rgt_a;   // right neighbor of first result in frame
    logic          lft_b;   // left neighbor of last-column result in frame
    logic          emit_a;  // result at window position 1
    logic          emit_b;  // result at window position 2
    logic          eof;
  } stg_t;

  // ---------------------------------------------------------------- registers
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[REG_SEL_LSB]);
  assign pready  = 1'b1;

  // Hold the frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_W'(RST_WIDTH);
      cfg_height_q <= CFG_W'(RST_HEIGHT);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  cfg_width_q  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_q <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  // Return the selected register
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(cfg_width_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(cfg_height_q);
    endcase
  end

  // Clamp the frame size into 1..MAX
  logic [31:0]   w_full, h_full;
  logic [AW-1:0] w_m1;
  logic [RW-1:0] h_m1;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_full = 32'd1;
    end else if (32'(cfg_width_q) > MAX_WIDTH) begin
      w_full = MAX_WIDTH;
    end else begin
      w_full = 32'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_full = 32'd1;
    end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
      h_full = MAX_HEIGHT;
    end else begin
      h_full = 32'(cfg_height_q);
    end
  end

  assign w_m1 = AW'(w_full - 32'd1);
  assign h_m1 = RW'(h_full - 32'd1);

  // ------------------------------------------------------------ stream control
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] col_q, col_d, drain_q, drain_d;
  logic          draining_q, draining_d;
  logic          in_acc, is_drain, do_pix, do_drn, rd_en;
  logic          col_last, row_last, drn_last;

  assign in_acc   = pix_i.valid & pix_i.ready;
  assign is_drain = (mode_e'(pix_i.mode) == MODE_DRAIN);
  assign do_pix   = in_acc & ~is_drain & ~draining_q;
  assign do_drn   = in_acc & is_drain & draining_q;
  assign rd_en    = do_pix | do_drn;
  assign col_last = (col_q == w_m1);
  assign row_last = (row_q == h_m1);
  assign drn_last = (drain_q == w_m1);

  // Advance the raster position
  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    drain_d    = drain_q;
    draining_d = draining_q;
    if (cfg_wr) begin
      row_d      = '0;
      col_d      = '0;
      drain_d    = '0;
      draining_d = 1'b0;
    end else if (do_pix) begin
      if (col_last) begin
        col_d = '0;
        if (row_last) begin
          draining_d = 1'b1;
          drain_d    = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (do_drn) begin
      if (drn_last) begin
        row_d      = '0;
        col_d      = '0;
        drain_d    = '0;
        draining_d = 1'b0;
      end else begin
        drain_d = drain_q + 1'b1;
      end
    end
  end

  // Describe the accepted word
  stg_t s0;

  always_comb begin
    s0.drain = do_drn;
    s0.first = (drain_q == '0);
    s0.col   = do_drn ? drain_q : col_q;
    s0.pixel = PW'(pix_i.pixel);
    if (do_drn) begin
      s0.orow   = h_m1;
      s0.ocol   = drain_q;
      s0.top_ok = (h_m1 != '0);
      s0.bot_ok = 1'b0;
      s0.lft_a  = (drain_q != '0);
      s0.rgt_a  = ~drn_last;
      s0.lft_b  = 1'b0;
      s0.emit_a = 1'b1;
      s0.emit_b = 1'b0;
      s0.eof    = drn_last;
    end else begin
      s0.orow   = row_q - 1'b1;
      s0.ocol   = col_q - 1'b1;
      s0.top_ok = (row_q > RW'(1));
      s0.bot_ok = 1'b1;
      s0.lft_a  = (col_q > AW'(1));
      s0.rgt_a  = 1'b1;
      s0.lft_b  = (col_q != '0);
      s0.emit_a = (row_q != '0) && (col_q != '0);
      s0.emit_b = (row_q != '0) && col_last;
      s0.eof    = 1'b0;
    end
  end

  // ------------------------------------------------------------- line memories
  pix_t          prev_mem [MAX_WIDTH];
  pix_t          sec_mem  [MAX_WIDTH];
  logic [AW-1:0] addr_a;
  pix_t          prev_a_q, sec_a_q, prev_b_q, sec_b_q;
  pix_t          fwd_prev_q, fwd_sec_q;
  logic          fwd_a_q, fwd_b_q;
  pix_t          prev_a, sec_a, prev_b, sec_b;
  stg_t          s1_q, s2_q;
  logic          s1_vld_q, s2_vld_q;
  logic          s1_wr;

  // Drain words fetch the column to the right of the center
  assign addr_a = do_drn ? AW'(drain_q + 1'b1) : col_q;
  assign s1_wr  = s1_vld_q & ~s1_q.drain;

  // Take the write of the word one stage ahead when it hits the same entry
  assign prev_a = fwd_a_q ? fwd_prev_q : prev_a_q;
  assign sec_a  = fwd_a_q ? fwd_sec_q  : sec_a_q;
  assign prev_b = fwd_b_q ? fwd_prev_q : prev_b_q;
  assign sec_b  = fwd_b_q ? fwd_sec_q  : sec_b_q;

  // Write back the shifted column
  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      prev_mem[s1_q.col] <= s1_q.pixel;
      sec_mem[s1_q.col]  <= prev_a;
    end
  end

  // Read the stores for the accepted word
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      prev_a_q   <= prev_mem[addr_a];
      sec_a_q    <= sec_mem[addr_a];
      prev_b_q   <= prev_mem[AW'(0)];
      sec_b_q    <= sec_mem[AW'(0)];
      fwd_a_q    <= s1_wr && (s1_q.col == addr_a);
      fwd_b_q    <= s1_wr && (s1_q.col == '0);
      fwd_prev_q <= s1_q.pixel;
      fwd_sec_q  <= prev_a;
      s1_q       <= s0;
    end
    s2_q <= s1_q;
  end

  // ------------------------------------------------------------------ window
  pix_t  ctr_q [WIN-1];  // center pixels at positions 1 and 2
  csum_t cs_q  [WIN];    // masked column sums at positions 0..2
  csum_t cs_new, cs_first;

  assign cs_new   = CS_W'(s1_q.top_ok ? sec_a : '0) + CS_W'(prev_a)
                  + CS_W'(s1_q.bot_ok ? s1_q.pixel : '0);
  assign cs_first = CS_W'(s1_q.top_ok ? sec_b : '0) + CS_W'(prev_b);

  // Shift in the new column, or load two columns for the first drain word
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      if (s1_q.drain && s1_q.first) begin
        ctr_q[0] <= prev_b;
        ctr_q[1] <= prev_a;
        cs_q[1]  <= cs_first;
        cs_q[2]  <= cs_new;
      end else begin
        ctr_q[0] <= ctr_q[1];
        ctr_q[1] <= prev_a;
        cs_q[0]  <= cs_q[1];
        cs_q[1]  <= cs_q[2];
        cs_q[2]  <= cs_new;
      end
    end
  end

  // ---------------------------------------------------------------- decision
  logic [1:0]       rows, cols_a, cols_b;
  logic [3:0]       cnt_a, cnt_b;
  logic [SUM_W-1:0] sum_a, sum_b, prod_a, prod_b;
  res_t             res_a, res_b, push0;
  logic [1:0]       npush;

  assign rows   = 2'd1 + {1'b0, s2_q.top_ok} + {1'b0, s2_q.bot_ok};
  assign cols_a = 2'd1 + {1'b0, s2_q.lft_a} + {1'b0, s2_q.rgt_a};
  assign cols_b = 2'd1 + {1'b0, s2_q.lft_b};
  assign cnt_a  = {2'b00, rows} * {2'b00, cols_a};
  assign cnt_b  = {2'b00, rows} * {2'b00, cols_b};

  assign sum_a  = SUM_W'(s2_q.lft_a ? cs_q[0] : '0) + SUM_W'(cs_q[1])
                + SUM_W'(s2_q.rgt_a ? cs_q[2] : '0);
  assign sum_b  = SUM_W'(s2_q.lft_b ? cs_q[1] : '0) + SUM_W'(cs_q[2]);
  assign prod_a = SUM_W'(ctr_q[0]) * SUM_W'(cnt_a);
  assign prod_b = SUM_W'(ctr_q[1]) * SUM_W'(cnt_b);

  always_comb begin
    res_a.above_mean   = (prod_a > sum_a);
    res_a.out_row      = POS_W'(s2_q.orow);
    res_a.out_col      = POS_W'(s2_q.ocol);
    res_a.last_in_run  = ~s2_q.emit_b;
    res_a.end_of_frame = s2_q.eof;
    res_b.above_mean   = (prod_b > sum_b);
    res_b.out_row      = POS_W'(s2_q.orow);
    res_b.out_col      = POS_W'(s2_q.col);
    res_b.last_in_run  = 1'b1;
    res_b.end_of_frame = 1'b0;
    push0              = s2_q.emit_a ? res_a : res_b;
    npush              = s2_vld_q ? ({1'b0, s2_q.emit_a} + {1'b0, s2_q.emit_b}) : 2'd0;
  end

  // ------------------------------------------------------------- result queue
  res_t             fifo_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q, wr_nxt;
  logic [CNT_W-1:0] cnt_q;
  logic [OCC_W-1:0] occ;
  logic             pop;
  res_t             head;

  assign wr_nxt = wr_q + PTR_W'(1);
  assign pop    = res_o.valid & res_o.ready;
  assign head   = fifo_q[rd_q];

  // Reserve room for every word still in flight plus the next one
  assign occ = OCC_W'(cnt_q)
             + OCC_W'(s1_vld_q & s1_q.emit_a) + OCC_W'(s1_vld_q & s1_q.emit_b)
             + OCC_W'(s2_vld_q & s2_q.emit_a) + OCC_W'(s2_vld_q & s2_q.emit_b)
             + OCC_W'(2);
  assign pix_i.ready = (occ <= OCC_W'(RES_DEPTH));

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      fifo_q[wr_q] <= push0;
    end
    if (npush == 2'd2) begin
      fifo_q[wr_nxt] <= res_b;
    end
  end

  assign res_o.valid        = (cnt_q != '0);
  assign res_o.above_mean   = head.above_mean;
  assign res_o.out_row      = head.out_row;
  assign res_o.out_col      = head.out_col;
  assign res_o.last_in_run  = head.last_in_run;
  assign res_o.end_of_frame = head.end_of_frame;

  // ------------------------------------------------------------ control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      drain_q    <= '0;
      draining_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      drain_q    <= drain_d;
      draining_q <= draining_d;
      s1_vld_q   <= rd_en;
      s2_vld_q   <= s1_vld_q;
      wr_q       <= wr_q + PTR_W'(npush);
      rd_q       <= rd_q + PTR_W'(pop);
      cnt_q      <= cnt_q + CNT_W'(npush) - CNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  // Queue room reserved at accept covers every push
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (OCC_W'(cnt_q) + OCC_W'(npush)) <= OCC_W'(RES_DEPTH))
    else $error("result queue overflow");

  // Draining parks the position on the last row, first column
  a_drain_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> (row_q == h_m1) && (col_q == '0))
    else $error("raster position moved while draining");

  // Column and drain counters stay inside the frame
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= w_m1) && (drain_q <= w_m1))
    else $error("column counter outside frame");

  // The frame's last result closes its word
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.end_of_frame |-> res_o.last_in_run)
    else $error("end of frame without last_in_run");
`endif

endmodule

[tb/sv/tb_local_mean_threshold_3x3.sv]
`timescale 1ns / 100ps

module tb_local_mean_threshold_3x3;
  import lmt_pkg::*;

  localparam int MAX_W    = DEF_MAX_WIDTH;
  localparam int MAX_H    = DEF_MAX_HEIGHT;
  localparam int R        = RADIUS;
  localparam int RAND_WORDS = 1150;
  localparam int SETTLE   = 10;

  typedef struct {
    mode_e               md;
    logic [PIX_IN_W-1:0] px;
  } pix_word_t;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lmt_in_if  pix_if ();
  lmt_out_if res_if ();

  local_mean_threshold_3x3 DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and expectations
  pix_word_t words_to_send [$];
  res_t      pending_decisions [$];

  int send_gap_pct;
  int stall_pct;
  int gap_left;
  int stall_left;

  int errors;
  int checked;
  int pixel_words;
  int drain_words;
  int dropped_words;
  int settings;

  // Shadow of the block state
  logic [CFG_W-1:0]    cfg_w;
  logic [CFG_W-1:0]    cfg_h;
  logic [PIX_IN_W-1:0] line_prev  [0:MAX_W-1];
  logic [PIX_IN_W-1:0] line_prev2 [0:MAX_W-1];
  logic [PIX_IN_W-1:0] win [0:2][0:2];
  int                  pos_row;
  int                  pos_col;
  int                  drain_col;
  bit                  draining;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout at %0t, %0d results still pending", $time, pending_decisions.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int eff_size(logic [CFG_W-1:0] v, int lim);
    if (v == '0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic void restart_stream();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = '0;
    pos_row   = 0;
    pos_col   = 0;
    drain_col = 0;
    draining  = 1'b0;
  endfunction

  // Window column pos holds frame column cc, window row i holds frame row rr-1+i
  function automatic logic win_above(int pos, int rr, int cc, int w, int h);
    longint unsigned sum;
    longint unsigned cnt;
    longint unsigned ctr;
    int fr;
    int p;
    int fc;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      fr = rr - R + i;
      if (fr >= 0 && fr < h) begin
        for (int d = -R; d <= R; d++) begin
          p  = pos + d;
          fc = cc + d;
          if (p >= 0 && p <= 2 && fc >= 0 && fc < w) begin
            sum += win[i][p];
            cnt++;
          end
        end
      end
    end
    ctr = win[1][pos];
    return (ctr * cnt) > sum;
  endfunction

  // Last row: neighbors come from the two line stores only
  function automatic logic drain_above(int d, int w, int h);
    longint unsigned sum;
    longint unsigned cnt;
    longint unsigned ctr;
    sum = 0;
    cnt = 0;
    for (int c = d - R; c <= d + R; c++) begin
      if (c >= 0 && c < w) begin
        sum += line_prev[c];
        cnt++;
        if (h >= 2) begin
          sum += line_prev2[c];
          cnt++;
        end
      end
    end
    ctr = line_prev[d];
    return (ctr * cnt) > sum;
  endfunction

  // Advance the shadow state by one accepted word and queue its results
  function automatic void predict_threshold(mode_e md, logic [PIX_IN_W-1:0] px);
    int   w;
    int   h;
    int   r;
    int   c;
    res_t e;
    w = eff_size(cfg_w, MAX_W);
    h = eff_size(cfg_h, MAX_H);
    if (md == MODE_DRAIN) begin
      if (!draining) begin
        dropped_words++;
        return;
      end
      drain_words++;
      c = (drain_col >= w) ? w - 1 : drain_col;
      e.above_mean   = drain_above(c, w, h);
      e.out_row      = POS_W'(h - 1);
      e.out_col      = POS_W'(c);
      e.last_in_run  = 1'b1;
      e.end_of_frame = (c == w - 1);
      pending_decisions.push_back(e);
      if (c + 1 >= w) restart_stream();
      else drain_col = c + 1;
      return;
    end
    if (draining) begin
      dropped_words++;
      return;
    end
    pixel_words++;
    r = pos_row;
    c = (pos_col >= w) ? w - 1 : pos_col;
    // shift the window left and load the new column
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_prev2[c];
    win[1][2] = line_prev[c];
    win[2][2] = px;
    line_prev2[c] = line_prev[c];
    line_prev[c]  = px;
    if (r >= 1) begin
      if (c >= 1) begin
        e.above_mean   = win_above(1, r - 1, c - 1, w, h);
        e.out_row      = POS_W'(r - 1);
        e.out_col      = POS_W'(c - 1);
        e.last_in_run  = (c != w - 1);
        e.end_of_frame = 1'b0;
        pending_decisions.push_back(e);
      end
      if (c == w - 1) begin
        e.above_mean   = win_above(2, r - 1, c, w, h);
        e.out_row      = POS_W'(r - 1);
        e.out_col      = POS_W'(c);
        e.last_in_run  = 1'b1;
        e.end_of_frame = 1'b0;
        pending_decisions.push_back(e);
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r         = h - 1;
        draining  = 1'b1;
        drain_col = 0;
      end
    end
    pos_row = r;
    pos_col = c;
  endfunction

  // Feed pixel and drain words; hold a word until it is taken
  always @(posedge clk_i) begin : drive_words
    pix_word_t nxt;
    if (rst_ni) begin
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left != 0) begin
          pix_if.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (words_to_send.size() != 0 && send_gap_pct != 0 &&
                     $urandom_range(0, 99) < send_gap_pct) begin
          pix_if.valid <= 1'b0;
          gap_left     <= $urandom_range(0, 16);
        end else if (words_to_send.size() != 0) begin
          nxt          = words_to_send.pop_front();
          pix_if.valid <= 1'b1;
          pix_if.mode  <= nxt.md;
          pix_if.pixel <= nxt.px;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side in bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 16);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Predict on every accepted word, check every accepted result
  always @(posedge clk_i) begin : watch_results
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready)
        predict_threshold(mode_e'(pix_if.mode), pix_if.pixel);
      if (res_if.valid && res_if.ready) begin
        got.above_mean   = res_if.above_mean;
        got.out_row      = res_if.out_row;
        got.out_col      = res_if.out_col;
        got.last_in_run  = res_if.last_in_run;
        got.end_of_frame = res_if.end_of_frame;
        if (pending_decisions.size() == 0) begin
          errors++;
          $display("%0t: unexpected result bit %0d row %0d col %0d last %0d eof %0d",
                   $time, got.above_mean, got.out_row, got.out_col, got.last_in_run,
                   got.end_of_frame);
        end else begin
          want = pending_decisions.pop_front();
          checked++;
          if (got !== want) begin
            errors++;
            $display({"%0t: mismatch, expected bit %0d row %0d col %0d last %0d eof %0d,",
                      " got bit %0d row %0d col %0d last %0d eof %0d"},
                     $time, want.above_mean, want.out_row, want.out_col,
                     want.last_in_run, want.end_of_frame, got.above_mean, got.out_row,
                     got.out_col, got.last_in_run, got.end_of_frame);
          end
        end
      end
    end
  end

  // Hold until every word is taken and every result is back, then settle
  task automatic wait_quiet();
    while (words_to_send.size() != 0 || pix_if.valid || pending_decisions.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    wait_quiet();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) << REG_SEL_LSB);
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_w = val;
    else cfg_h = val;
    restart_stream();
    settings++;
  endtask

  task automatic push_word(input mode_e md, input logic [PIX_IN_W-1:0] px);
    pix_word_t wd;
    wd.md = md;
    wd.px = px;
    words_to_send.push_back(wd);
  endtask

  // Queue one frame; noisy adds words the block must drop
  task automatic push_frame(input int w, input int h, input int n_pix, input int n_drain,
                            input bit noisy);
    int                  style;
    logic [PIX_IN_W-1:0] base;
    logic [PIX_IN_W-1:0] px;
    style = $urandom_range(0, 3);
    base  = PIX_IN_W'($urandom);
    if (noisy) push_word(MODE_DRAIN, PIX_IN_W'($urandom));
    for (int k = 0; k < n_pix; k++) begin
      case (style)
        0: px = PIX_IN_W'($urandom);
        1: px = base + PIX_IN_W'($urandom_range(0, 6));
        2: px = base;
        default: px = $urandom_range(0, 1) ? '1 : '0;
      endcase
      push_word(MODE_PIXEL, px);
    end
    if (noisy && n_pix == w * h) push_word(MODE_PIXEL, PIX_IN_W'($urandom));
    repeat (n_drain) push_word(MODE_DRAIN, PIX_IN_W'($urandom));
    if (noisy && n_drain == w) push_word(MODE_DRAIN, PIX_IN_W'($urandom));
  endtask

  initial begin : run_test
    int rand_words;
    int fw;
    int fh;
    int ew;
    int eh;
    int np;
    int nd;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_if.valid = 1'b0;
    pix_if.mode  = MODE_PIXEL;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    send_gap_pct = 6;
    stall_pct    = 6;
    gap_left     = 0;
    stall_left   = 0;
    errors       = 0;
    checked      = 0;
    pixel_words  = 0;
    drain_words  = 0;
    dropped_words = 0;
    settings     = 0;
    rand_words   = 0;
    cfg_w        = CFG_W'(RST_WIDTH);
    cfg_h        = CFG_W'(RST_HEIGHT);
    for (int i = 0; i < MAX_W; i++) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    restart_stream();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 frame: extremes, equal values, stray drain and stray pixel
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    push_word(MODE_DRAIN, 16'h1234);
    push_word(MODE_PIXEL, 16'h0000);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_PIXEL, 16'd7);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_PIXEL, 16'd100);
    push_word(MODE_PIXEL, 16'h0000);
    push_word(MODE_PIXEL, 16'd300);
    push_word(MODE_PIXEL, 16'd300);
    push_word(MODE_PIXEL, 16'd300);
    push_word(MODE_PIXEL, 16'd123);
    repeat (3) push_word(MODE_DRAIN, 16'hEDCB);
    push_word(MODE_DRAIN, 16'h5555);

    // zero sizes act as one: a single pixel frame
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_DRAIN, 16'hAAAA);

    // one row of equal pixels
    write_reg(REG_FRAME_WIDTH, 13'd2);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    push_word(MODE_PIXEL, 16'd9);
    push_word(MODE_PIXEL, 16'd9);
    push_word(MODE_DRAIN, 16'h0000);
    push_word(MODE_DRAIN, 16'hFFFF);

    // one column of two rows
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    push_word(MODE_PIXEL, 16'h0000);
    push_word(MODE_PIXEL, 16'hFFFF);
    push_word(MODE_DRAIN, 16'h0F0F);

    // random small frames, mostly complete, some broken or noisy
    while (rand_words < RAND_WORDS) begin
      fw = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      fh = $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) fw = 0;
      if ($urandom_range(0, 15) == 0) fh = 0;
      write_reg(REG_FRAME_WIDTH, CFG_W'(fw));
      write_reg(REG_FRAME_HEIGHT, CFG_W'(fh));
      send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      ew = (fw == 0) ? 1 : fw;
      eh = (fh == 0) ? 1 : fh;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) begin
          np = $urandom_range(0, ew * eh);
          nd = (np == ew * eh) ? $urandom_range(0, ew - 1) : 0;
          push_frame(ew, eh, np, nd, 1'b1);
          rand_words += np + nd;
          break;
        end
        push_frame(ew, eh, ew * eh, ew, $urandom_range(0, 4) == 0);
        rand_words += ew * eh + ew;
      end
    end

    // clamped height: a tall single column cut short, with no idling
    wait_quiet();
    send_gap_pct = 0;
    stall_pct    = 0;
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    push_frame(1, MAX_H, 64, 0, 1'b0);

    wait_quiet();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d results from %0d pixel words and %0d drain words (%0d dropped)",
             checked, pixel_words, drain_words, dropped_words);
    $display("over %0d register writes, frames from 1x1 up to 64 wide and a clamped height",
             settings);
    if (errors == 0 && pending_decisions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
